// ===== sv/psco_pkg.sv =====
package psco_pkg;

  // Result selection for one word
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_START  = 2'd0;  // degenerate segment or before start: A - P
  localparam mode_t MODE_END    = 2'd1;  // beyond end: B - P
  localparam mode_t MODE_INTERP = 2'd2;  // inside: A + t*D - P

endpackage

// ===== sv/psco_if.sv =====
interface psco_in_if #(
  parameter int CW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] start_z;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] end_z;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z,
    output point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
    input  point_x, point_y, point_z,
    output ready
  );
endinterface

interface psco_out_if #(
  parameter int CW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] offset_x;
  logic signed [CW-1:0] offset_y;
  logic signed [CW-1:0] offset_z;

  modport source (output valid, offset_x, offset_y, offset_z, input ready);
  modport sink   (input valid, offset_x, offset_y, offset_z, output ready);
endinterface

// ===== sv/psco_front.sv =====
module psco_front #(
  parameter int CW = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [CW-1:0]   a_i [3],
  input  logic signed [CW-1:0]   b_i [3],
  input  logic signed [CW-1:0]   p_i [3],
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic signed [2*CW+3:0] num_o,
  output logic signed [2*CW+3:0] den_o,
  output logic signed [CW:0]     d_o [3],
  output logic signed [CW:0]     e_o [3]
);

  localparam int PW = 2*CW + 2;
  localparam int NW = 2*CW + 4;

  logic                 v1_r, v2_r, v3_r;
  logic                 en1, en2, en3;
  logic signed [CW:0]   d1_r [3];
  logic signed [CW:0]   e1_r [3];
  logic signed [CW:0]   d2_r [3];
  logic signed [CW:0]   e2_r [3];
  logic signed [PW-1:0] dd2_r [3];
  logic signed [PW-1:0] de2_r [3];
  logic signed [CW:0]   d3_r [3];
  logic signed [CW:0]   e3_r [3];
  logic signed [NW-1:0] num3_r, den3_r;

  // Stage advances when empty or when the next one advances
  assign en3     = !v3_r || ready_i;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign ready_o = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= valid_i;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Differences D = B - A and E = P - A
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k] <= {b_i[k][CW-1], b_i[k]} - {a_i[k][CW-1], a_i[k]};
        e1_r[k] <= {p_i[k][CW-1], p_i[k]} - {a_i[k][CW-1], a_i[k]};
      end
    end
  end

  // Products per component
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 3; k++) begin
        dd2_r[k] <= d1_r[k] * d1_r[k];
        de2_r[k] <= d1_r[k] * e1_r[k];
        d2_r[k]  <= d1_r[k];
        e2_r[k]  <= e1_r[k];
      end
    end
  end

  // Dot products
  always_ff @(posedge clk) begin
    if (en3) begin
      num3_r <= NW'(de2_r[0]) + NW'(de2_r[1]) + NW'(de2_r[2]);
      den3_r <= NW'(dd2_r[0]) + NW'(dd2_r[1]) + NW'(dd2_r[2]);
      for (int k = 0; k < 3; k++) begin
        d3_r[k] <= d2_r[k];
        e3_r[k] <= e2_r[k];
      end
    end
  end

  assign valid_o = v3_r;
  assign num_o   = num3_r;
  assign den_o   = den3_r;
  assign d_o     = d3_r;
  assign e_o     = e3_r;

endmodule

// ===== sv/psco_div.sv =====
module psco_div #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [2*CW+3:0] num_i,
  input  logic signed [2*CW+3:0] den_i,
  input  logic signed [CW:0]     d_i [3],
  input  logic signed [CW:0]     e_i [3],
  output logic                   valid_o,
  input  logic                   ready_i,
  output psco_pkg::mode_t        mode_o,
  output logic [FB:0]            t_o,
  output logic signed [CW:0]     d_o [3],
  output logic signed [CW:0]     e_o [3]
);

  localparam int NW = 2*CW + 4;

  logic                  v_r    [FB+1];
  logic                  en     [FB+1];
  psco_pkg::mode_t       mode_r [FB+1];
  logic [FB:0]           q_r    [FB+1];
  logic [NW-1:0]         rem_r  [FB];
  logic [NW-1:0]         den_r  [FB];
  logic signed [CW:0]    d_r    [FB+1][3];
  logic signed [CW:0]    e_r    [FB+1][3];
  psco_pkg::mode_t       mode0;
  logic                  q0;

  // Stall chain from the output back
  always_comb begin
    en[FB] = !v_r[FB] || ready_i;
    for (int i = FB - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end
  assign ready_o = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= FB; i++) v_r[i] <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= valid_i;
      for (int i = 1; i <= FB; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Classify and take the integer bit of the ratio
  always_comb begin
    if (den_i == '0 || num_i[NW-1]) begin
      mode0 = psco_pkg::MODE_START;
    end else if (num_i > den_i) begin
      mode0 = psco_pkg::MODE_END;
    end else begin
      mode0 = psco_pkg::MODE_INTERP;
    end
    q0 = (num_i == den_i);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mode_r[0] <= mode0;
      q_r[0]    <= (FB+1)'(q0);
      rem_r[0]  <= q0 ? '0 : num_i;
      den_r[0]  <= den_i;
      d_r[0]    <= d_i;
      e_r[0]    <= e_i;
    end
  end

  // One quotient bit per stage
  for (genvar i = 1; i <= FB; i++) begin : g_step
    logic [NW:0] sh;
    logic        ge;

    assign sh = {rem_r[i-1], 1'b0};
    assign ge = sh >= {1'b0, den_r[i-1]};

    always_ff @(posedge clk) begin
      if (en[i]) begin
        mode_r[i] <= mode_r[i-1];
        q_r[i]    <= {q_r[i-1][FB-1:0], ge};
        d_r[i]    <= d_r[i-1];
        e_r[i]    <= e_r[i-1];
      end
    end

    if (i < FB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[i]) begin
          rem_r[i] <= ge ? NW'(sh - {1'b0, den_r[i-1]}) : NW'(sh);
          den_r[i] <= den_r[i-1];
        end
      end
    end
  end

  assign valid_o = v_r[FB];
  assign mode_o  = mode_r[FB];
  assign t_o     = q_r[FB];
  assign d_o     = d_r[FB];
  assign e_o     = e_r[FB];

endmodule

// ===== sv/psco_back.sv =====
module psco_back #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  psco_pkg::mode_t      mode_i,
  input  logic [FB:0]          t_i,
  input  logic signed [CW:0]   d_i [3],
  input  logic signed [CW:0]   e_i [3],
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [CW-1:0] res_o [3]
);

  localparam int MW = FB + CW + 3;

  logic                 v1_r, v2_r;
  logic                 en1, en2;
  psco_pkg::mode_t      mode1_r;
  logic signed [MW-1:0] prod1_r [3];
  logic signed [CW:0]   d1_r [3];
  logic signed [CW:0]   e1_r [3];
  logic signed [CW-1:0] res2_r [3];
  logic signed [CW-1:0] res_nxt [3];

  assign en2     = !v2_r || ready_i;
  assign en1     = !v1_r || en2;
  assign ready_o = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= valid_i;
      if (en2) v2_r <= v1_r;
    end
  end

  // Scale D by the ratio
  always_ff @(posedge clk) begin
    if (en1) begin
      mode1_r <= mode_i;
      for (int k = 0; k < 3; k++) begin
        prod1_r[k] <= $signed({1'b0, t_i}) * d_i[k];
        d1_r[k]    <= d_i[k];
        e1_r[k]    <= e_i[k];
      end
    end
  end

  // Select the offset and saturate
  always_comb begin
    logic signed [CW:0]   s;
    logic signed [CW+1:0] v;
    for (int k = 0; k < 3; k++) begin
      s = (CW+1)'(prod1_r[k] >>> FB);
      case (mode1_r)
        psco_pkg::MODE_START: v = -{e1_r[k][CW], e1_r[k]};
        psco_pkg::MODE_END:   v = {d1_r[k][CW], d1_r[k]} - {e1_r[k][CW], e1_r[k]};
        default:              v = {s[CW], s} - {e1_r[k][CW], e1_r[k]};
      endcase
      if (v[CW+1:CW-1] == 3'b000 || v[CW+1:CW-1] == 3'b111) begin
        res_nxt[k] = v[CW-1:0];
      end else if (v[CW+1]) begin
        res_nxt[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        res_nxt[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) res2_r <= res_nxt;
  end

  assign valid_o = v2_r;
  assign res_o   = res2_r;

endmodule

// ===== sv/point_segment_closest_offset.sv =====
// Closest point on a 3D segment, given as an offset from a query point.
//
// in_ch carries one word per query: segment start A, segment end B and
// query point P, signed fixed point with FRAC_BITS fraction bits. out_ch
// returns C - P, C being the closest point on the segment, each component
// saturated to COORD_WIDTH signed bits. Both channels use valid/ready; a
// word moves at a clock edge with both high.
//
// Three stages form the differences, products and dot products,
// FRAC_BITS + 1 stages of the restoring divider make one ratio bit each,
// and two stages scale D and select/saturate into the output register.
// One word enters per cycle while input ready is high.
//
// Synchronous active-low reset empties every stage. When the receiver
// stalls, the output register holds its word and each stage keeps filling
// until it meets an occupied one, so input ready drops only once the
// pipeline has no bubble left.
module point_segment_closest_offset #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  psco_in_if.sink    in_ch,
  psco_out_if.source out_ch
);

  localparam int CW = COORD_WIDTH;
  localparam int FB = FRAC_BITS;

  logic signed [CW-1:0]   a [3];
  logic signed [CW-1:0]   b [3];
  logic signed [CW-1:0]   p [3];
  logic                   f_valid, f_ready;
  logic signed [2*CW+3:0] f_num, f_den;
  logic signed [CW:0]     f_d [3];
  logic signed [CW:0]     f_e [3];
  logic                   q_valid, q_ready;
  psco_pkg::mode_t        q_mode;
  logic [FB:0]            q_t;
  logic signed [CW:0]     q_d [3];
  logic signed [CW:0]     q_e [3];
  logic signed [CW-1:0]   res [3];

  assign a[0] = in_ch.start_x;
  assign a[1] = in_ch.start_y;
  assign a[2] = in_ch.start_z;
  assign b[0] = in_ch.end_x;
  assign b[1] = in_ch.end_y;
  assign b[2] = in_ch.end_z;
  assign p[0] = in_ch.point_x;
  assign p[1] = in_ch.point_y;
  assign p[2] = in_ch.point_z;

  psco_front #(.CW(CW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_ch.valid),
    .ready_o (in_ch.ready),
    .a_i     (a),
    .b_i     (b),
    .p_i     (p),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .num_o   (f_num),
    .den_o   (f_den),
    .d_o     (f_d),
    .e_o     (f_e)
  );

  psco_div #(.CW(CW), .FB(FB)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .num_i   (f_num),
    .den_i   (f_den),
    .d_i     (f_d),
    .e_i     (f_e),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .mode_o  (q_mode),
    .t_o     (q_t),
    .d_o     (q_d),
    .e_o     (q_e)
  );

  psco_back #(.CW(CW), .FB(FB)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (q_valid),
    .ready_o (q_ready),
    .mode_i  (q_mode),
    .t_i     (q_t),
    .d_i     (q_d),
    .e_i     (q_e),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .res_o   (res)
  );

  assign out_ch.offset_x = res[0];
  assign out_ch.offset_y = res[1];
  assign out_ch.offset_z = res[2];

  // Reset leaves no word in flight
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  // An accepting receiver never backs up the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output drains");

  // Stall chain: inner handshake never blocks with downstream open
  a_inner_flow: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> f_ready)
    else $error("divider stalled while back end accepts");

endmodule

// ===== tb/tb_point_segment_closest_offset.sv =====
module tb_point_segment_closest_offset;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int N_RANDOM = 1200;
  localparam int LATENCY = FB + 6;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    coord_t ax, ay, az, bx, by, bz, px, py, pz;
  } query_t;

  typedef struct packed {
    coord_t ox, oy, oz;
  } offset_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psco_in_if  #(.CW(CW)) in_ch ();
  psco_out_if #(.CW(CW)) out_ch ();

  point_segment_closest_offset #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  query_t  query_q[$];
  offset_t offset_q[$];
  int      n_errors = 0;
  int      n_accepted = 0;
  int      n_checked = 0;
  int      mode_hits[3] = '{0, 0, 0};
  bit      stim_done = 1'b0;
  bit      long_hold = 1'b0;

  // Clamp a wide value into the signed coordinate range
  function automatic coord_t clamp_coord(wide_t v);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

  // Closest point on segment AB minus P, with the selected mode
  function automatic offset_t closest_offset(query_t q, output psco_pkg::mode_t mode);
    wide_t a[3], b[3], p[3], d[3], num, den, t, s;
    coord_t r[3];
    offset_t o;
    a = '{wide_t'(q.ax), wide_t'(q.ay), wide_t'(q.az)};
    b = '{wide_t'(q.bx), wide_t'(q.by), wide_t'(q.bz)};
    p = '{wide_t'(q.px), wide_t'(q.py), wide_t'(q.pz)};
    num = 0;
    den = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = b[k] - a[k];
      num += d[k] * (p[k] - a[k]);
      den += d[k] * d[k];
    end
    if (den == 0 || num < 0) mode = psco_pkg::MODE_START;
    else if (num > den) mode = psco_pkg::MODE_END;
    else mode = psco_pkg::MODE_INTERP;
    t = (mode == psco_pkg::MODE_INTERP) ? (num <<< FB) / den : 0;
    for (int k = 0; k < 3; k++) begin
      case (mode)
        psco_pkg::MODE_START: r[k] = clamp_coord(a[k] - p[k]);
        psco_pkg::MODE_END:   r[k] = clamp_coord(b[k] - p[k]);
        default: begin
          s = (t * d[k]) >>> FB;
          r[k] = clamp_coord(a[k] + s - p[k]);
        end
      endcase
    end
    o.ox = r[0];
    o.oy = r[1];
    o.oz = r[2];
    return o;
  endfunction

  function automatic coord_t rand_coord(int span);
    if (span >= 32) return coord_t'($urandom);
    return coord_t'($signed($urandom_range((1 << span) - 1, 0)) - (1 << (span - 1)));
  endfunction

  // Random query: wide noise, small segments, points near the segment, degenerate
  function automatic query_t rand_query();
    query_t q;
    int span;
    int kind;
    kind = $urandom_range(9, 0);
    span = (kind < 2) ? 32 : $urandom_range(30, 4);
    q = {rand_coord(span), rand_coord(span), rand_coord(span),
         rand_coord(span), rand_coord(span), rand_coord(span),
         rand_coord(span), rand_coord(span), rand_coord(span)};
    if (kind == 2) begin
      q.bx = q.ax;
      q.by = q.ay;
      q.bz = q.az;
    end else if (kind >= 6 && span < 30) begin
      // put P between A and B, lightly perturbed
      q.px = q.ax + (q.bx - q.ax) / 2 + rand_coord(8);
      q.py = q.ay + (q.by - q.ay) / 2 + rand_coord(8);
      q.pz = q.az + (q.bz - q.az) / 2 + rand_coord(8);
    end
    return q;
  endfunction

  // Fill the stimulus queue: directed corners first, then random queries
  initial begin
    coord_t mx, mn, one;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    one = coord_t'(1) <<< FB;
    query_q.push_back('0);
    query_q.push_back({mx, mx, mx, mx, mx, mx, mx, mx, mx});
    query_q.push_back({mn, mn, mn, mn, mn, mn, mn, mn, mn});
    query_q.push_back({mx, mx, mx, mx, mx, mx, mn, mn, mn});
    query_q.push_back({mn, mn, mn, mn, mn, mn, mx, mx, mx});
    query_q.push_back({mn, mn, mn, mx, mx, mx, coord_t'(0), coord_t'(0), coord_t'(0)});
    query_q.push_back({mx, mn, mx, mn, mx, mn, mn, mx, mn});
    query_q.push_back({mn, mx, mn, mx, mn, mx, mx, mn, mx});
    query_q.push_back({coord_t'(0), coord_t'(0), coord_t'(0), one, one, one,
                       -one, -one, -one});
    query_q.push_back({coord_t'(0), coord_t'(0), coord_t'(0), one, one, one,
                       one * 3, one * 3, one * 3});
    query_q.push_back({coord_t'(0), coord_t'(0), coord_t'(0), one, one, one,
                       one, one, one});
    query_q.push_back({coord_t'(0), coord_t'(0), coord_t'(0), one, coord_t'(0),
                       coord_t'(0), one / 3, one, -one});
    query_q.push_back({-one, -one, -one, one, one, one, coord_t'(1), coord_t'(0),
                       coord_t'(-1)});
    query_q.push_back({coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(3),
                       coord_t'(0), coord_t'(0), coord_t'(1), coord_t'(0),
                       coord_t'(0)});
    query_q.push_back({mx, mx, mx, mn, mn, mn, coord_t'(-1), coord_t'(-1),
                       coord_t'(-1)});
    query_q.push_back({one, one, one, one, one, one, mn, mx, coord_t'(0)});
    for (int i = 0; i < N_RANDOM; i++) query_q.push_back(rand_query());
  end

  // Reset once, then release on a falling edge
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Sender: bursts of random length separated by random gaps
  int send_burst = 0;
  int send_gap = 0;
  bit in_taken = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.start_x, in_ch.start_y, in_ch.start_z, in_ch.end_x, in_ch.end_y,
     in_ch.end_z, in_ch.point_x, in_ch.point_y, in_ch.point_z} = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    query_t q;
    if (rst_n && !(in_ch.valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (query_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        q = query_q.pop_front();
        in_ch.valid <= 1'b1;
        {in_ch.start_x, in_ch.start_y, in_ch.start_z, in_ch.end_x, in_ch.end_y,
         in_ch.end_z, in_ch.point_x, in_ch.point_y, in_ch.point_z} <= q;
        if (send_burst > 1) begin
          send_burst <= send_burst - 1;
        end else begin
          send_burst <= $urandom_range(40, 1);
          send_gap <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off
  int stall_phase = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      stall_phase <= (stall_phase + 1) % 64;
      out_ch.ready <= !long_hold && (stall_phase < 24 || $urandom_range(2, 0) != 0);
    end
  end

  initial begin
    wait (n_accepted >= 400);
    long_hold = 1'b1;
    repeat (300) @(posedge clk);
    long_hold = 1'b0;
  end

  // Accept input words and predict; check output words against the oldest prediction
  always @(posedge clk) begin
    query_t          q;
    offset_t         want, got;
    psco_pkg::mode_t mode;
    in_taken = 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      q = {in_ch.start_x, in_ch.start_y, in_ch.start_z, in_ch.end_x, in_ch.end_y,
           in_ch.end_z, in_ch.point_x, in_ch.point_y, in_ch.point_z};
      offset_q.push_back(closest_offset(q, mode));
      mode_hits[mode]++;
      n_accepted++;
      in_taken = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.offset_x, out_ch.offset_y, out_ch.offset_z};
      if (offset_q.size() == 0) begin
        $error("unexpected output word %h", got);
        n_errors++;
      end else begin
        want = offset_q.pop_front();
        n_checked++;
        if (got.ox !== want.ox) begin
          $error("offset_x expected %0d got %0d", want.ox, got.ox);
          n_errors++;
        end
        if (got.oy !== want.oy) begin
          $error("offset_y expected %0d got %0d", want.oy, got.oy);
          n_errors++;
        end
        if (got.oz !== want.oz) begin
          $error("offset_z expected %0d got %0d", want.oz, got.oz);
          n_errors++;
        end
      end
    end
  end

  // Drain, then report
  initial begin
    wait (rst_n);
    wait (query_q.size() == 0 && !(in_ch.valid && !in_taken));
    wait (offset_q.size() == 0);
    repeat (LATENCY * 3) @(posedge clk);
    if (offset_q.size() != 0) n_errors++;
    $display("%0d queries in, %0d offsets checked", n_accepted, n_checked);
    $display("before start/degenerate %0d, beyond end %0d, interpolated %0d",
             mode_hits[psco_pkg::MODE_START], mode_hits[psco_pkg::MODE_END],
             mode_hits[psco_pkg::MODE_INTERP]);
    if (n_errors == 0) begin
      $display("tb_point_segment_closest_offset: done, clean");
    end else begin
      $display("tb_point_segment_closest_offset: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("tb_point_segment_closest_offset: done, errors");
    $finish;
  end

endmodule
